@@ src/atcs_pkg.sv @@
package atcs_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int FRAME_W     = 40;
    localparam int CH_CNT_W    = 4;
    localparam int CH_W        = 5;
    localparam int START_W     = 24;
    localparam int END_W       = 14;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_MAX_CHANNELS       = 8;
    localparam int DEF_TRIM_STORE_SAMPLES = 16384;

    localparam logic signed [SAMPLE_W-1:0] UNITY_Q23     = 32'sd8388608;
    localparam logic signed [SAMPLE_W-1:0] NEG_UNITY_Q23 = -32'sd8388608;
    localparam logic [FRAME_W-1:0]         FRAME_MAX     = '1;
    localparam logic [SAMPLE_W-1:0]        COUNT_MAX     = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIM_START    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIM_END      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMALISE     = 4'd3;

    typedef struct packed {
        logic [CH_CNT_W-1:0] channel_count;
        logic                start_load;
        logic [START_W-1:0]  trim_start;
        logic [END_W-1:0]    trim_end;
        logic                normalise;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } tap_t;

    function automatic logic [CH_W-1:0] eff_channels(input logic [CH_CNT_W-1:0] cnt,
                                                     input int max_ch);
        logic [CH_W-1:0] res;
        if (cnt == '0) begin
            res = CH_W'(1);
        end else if (int'(cnt) > max_ch) begin
            res = CH_W'(max_ch);
        end else begin
            res = CH_W'(cnt);
        end
        return res;
    endfunction

endpackage

@@ src/audio_trim_clip_stats.sv @@
// Trims and clips an interleaved Q8.23 sample stream and keeps running signal statistics.
// One sample is accepted per clock unless the output stalls, and the result for it,
// when there is one, is registered at the tap and then at the output. The sustained
// rate of one sample per cycle is set by the single write port and single read port
// of the delay RAM, each used once per sample. Samples of the first trim_start_frames
// frames and the first trim_end_frames * channels samples after them give no result;
// the end-trim delay is off when that product reaches TRIM_STORE_SAMPLES. No clearing
// pass follows reset. Write the registers only while the stream is idle.
module audio_trim_clip_stats #(
    parameter int MAX_CHANNELS       = atcs_pkg::DEF_MAX_CHANNELS,
    parameter int TRIM_STORE_SAMPLES = atcs_pkg::DEF_TRIM_STORE_SAMPLES
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [atcs_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [atcs_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [atcs_pkg::SAMPLE_W-1:0]   s_sample_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [atcs_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic [atcs_pkg::SAMPLE_W-1:0]          m_peak_abs,
    output logic [atcs_pkg::SAMPLE_W-1:0]          m_clip_count,
    output logic                                   m_any_nonzero,
    output logic [atcs_pkg::FRAME_W-1:0]           m_first_nonzero_frame,
    output logic [atcs_pkg::FRAME_W-1:0]           m_last_nonzero_frame
);

    logic [atcs_pkg::CH_CNT_W-1:0] channel_count_reg;
    logic [atcs_pkg::START_W-1:0]  trim_start_reg;
    logic [atcs_pkg::END_W-1:0]    trim_end_reg;
    logic                          normalise_reg;
    logic                          cfg_write;
    logic                          start_load;

    atcs_pkg::cfg_t cfg;
    atcs_pkg::tap_t tap;
    logic           tap_adv;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign start_load = cfg_write && (cfg_index == atcs_pkg::CFG_TRIM_START);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= atcs_pkg::CH_CNT_W'(1);
            trim_start_reg    <= '0;
            trim_end_reg      <= '0;
            normalise_reg     <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                atcs_pkg::CFG_CHANNEL_COUNT: begin
                    channel_count_reg <= cfg_data[atcs_pkg::CH_CNT_W-1:0];
                end
                atcs_pkg::CFG_TRIM_START: begin
                    trim_start_reg <= cfg_data[atcs_pkg::START_W-1:0];
                end
                atcs_pkg::CFG_TRIM_END: begin
                    trim_end_reg <= cfg_data[atcs_pkg::END_W-1:0];
                end
                atcs_pkg::CFG_NORMALISE: begin
                    normalise_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.channel_count = channel_count_reg;
    assign cfg.start_load    = start_load;
    assign cfg.trim_start    = cfg_data[atcs_pkg::START_W-1:0];
    assign cfg.trim_end      = trim_end_reg;
    assign cfg.normalise     = normalise_reg;

    atcs_front #(
        .MAX_CHANNELS       (MAX_CHANNELS),
        .TRIM_STORE_SAMPLES (TRIM_STORE_SAMPLES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .tap         (tap),
        .tap_adv     (tap_adv)
    );

    atcs_stats #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_stats (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg                   (cfg),
        .tap                   (tap),
        .tap_adv               (tap_adv),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_sample_out          (m_sample_out),
        .m_peak_abs            (m_peak_abs),
        .m_clip_count          (m_clip_count),
        .m_any_nonzero         (m_any_nonzero),
        .m_first_nonzero_frame (m_first_nonzero_frame),
        .m_last_nonzero_frame  (m_last_nonzero_frame)
    );

    a_start_reg_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        start_load |=> trim_start_reg == $past(cfg_data[atcs_pkg::START_W-1:0]))
        else $error("trim start register not loaded");

endmodule

@@ src/atcs_ram.sv @@
module atcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/atcs_front.sv @@
module atcs_front #(
    parameter int MAX_CHANNELS       = atcs_pkg::DEF_MAX_CHANNELS,
    parameter int TRIM_STORE_SAMPLES = atcs_pkg::DEF_TRIM_STORE_SAMPLES
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  atcs_pkg::cfg_t                         cfg,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [atcs_pkg::SAMPLE_W-1:0]   s_sample_in,
    output atcs_pkg::tap_t                         tap,
    input  logic                                   tap_adv
);

    localparam int PTR_W  = $clog2(TRIM_STORE_SAMPLES);
    localparam int FILL_W = PTR_W + 1;
    localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PROD_W = atcs_pkg::END_W + atcs_pkg::CH_W;

    logic [atcs_pkg::START_W-1:0]  start_left_reg;
    logic [POS_W-1:0]              pos_reg;
    logic [PTR_W-1:0]              wptr_reg;
    logic [FILL_W-1:0]             fill_reg;
    logic                          tap_valid_reg;
    logic                          bypass_reg;
    logic [atcs_pkg::SAMPLE_W-1:0] raw_reg;

    logic [atcs_pkg::CH_W-1:0]     ech;
    logic [PROD_W-1:0]             prod;
    logic [FILL_W-1:0]             dlen;
    logic                          frame_end;
    logic                          accept;
    logic                          in_trim;
    logic                          pass;
    logic                          produce;
    logic [PTR_W-1:0]              wptr_next;
    logic [FILL_W-1:0]             rd_wide;
    logic [PTR_W-1:0]              rd_addr;
    logic [atcs_pkg::SAMPLE_W-1:0] ram_rdata;

    assign ech  = atcs_pkg::eff_channels(cfg.channel_count, MAX_CHANNELS);
    assign prod = PROD_W'(cfg.trim_end) * PROD_W'(ech);
    assign dlen = (prod >= PROD_W'(TRIM_STORE_SAMPLES)) ? '0 : prod[FILL_W-1:0];

    assign frame_end = (atcs_pkg::CH_W'(pos_reg) + atcs_pkg::CH_W'(1)) >= ech;

    assign s_ready = !tap_valid_reg || tap_adv;
    assign accept  = s_valid && s_ready;
    assign in_trim = start_left_reg != '0;
    assign pass    = accept && !in_trim;
    assign produce = pass && (fill_reg >= dlen);

    assign wptr_next = (wptr_reg == PTR_W'(TRIM_STORE_SAMPLES - 1)) ? '0
                                                                  : wptr_reg + PTR_W'(1);
    assign rd_wide = (FILL_W'(wptr_reg) >= fill_reg)
                   ? FILL_W'(wptr_reg) - fill_reg
                   : FILL_W'(wptr_reg) + FILL_W'(TRIM_STORE_SAMPLES) - fill_reg;
    assign rd_addr = rd_wide[PTR_W-1:0];

    atcs_ram #(
        .WIDTH (atcs_pkg::SAMPLE_W),
        .DEPTH (TRIM_STORE_SAMPLES)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (pass),
        .waddr (wptr_reg),
        .wdata (s_sample_in),
        .re    (produce),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_left_reg <= '0;
            pos_reg        <= '0;
            wptr_reg       <= '0;
            fill_reg       <= '0;
            tap_valid_reg  <= 1'b0;
        end else begin
            if (cfg.start_load) begin
                start_left_reg <= cfg.trim_start;
            end else if (accept && in_trim && frame_end) begin
                start_left_reg <= start_left_reg - 1'b1;
            end
            if (accept) begin
                pos_reg <= frame_end ? '0 : pos_reg + POS_W'(1);
            end
            if (pass) begin
                wptr_reg <= wptr_next;
                if (fill_reg < dlen) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            if (produce) begin
                tap_valid_reg <= 1'b1;
            end else if (tap_adv) begin
                tap_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            bypass_reg <= fill_reg == '0;
            raw_reg    <= s_sample_in;
        end
    end

    assign tap.valid  = tap_valid_reg;
    assign tap.sample = bypass_reg ? raw_reg : ram_rdata;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < FILL_W'(TRIM_STORE_SAMPLES))
        else $error("delay fill beyond store size");

    a_wptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        FILL_W'(wptr_reg) < FILL_W'(TRIM_STORE_SAMPLES))
        else $error("write pointer beyond store size");

    a_trim_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_trim && !tap_valid_reg |=> !tap_valid_reg)
        else $error("result raised by a trimmed sample");

endmodule

@@ src/atcs_stats.sv @@
module atcs_stats #(
    parameter int MAX_CHANNELS = atcs_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  atcs_pkg::cfg_t                       cfg,
    input  atcs_pkg::tap_t                       tap,
    output logic                                 tap_adv,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [atcs_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic [atcs_pkg::SAMPLE_W-1:0]        m_peak_abs,
    output logic [atcs_pkg::SAMPLE_W-1:0]        m_clip_count,
    output logic                                 m_any_nonzero,
    output logic [atcs_pkg::FRAME_W-1:0]         m_first_nonzero_frame,
    output logic [atcs_pkg::FRAME_W-1:0]         m_last_nonzero_frame
);

    localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic                          m_valid_reg;
    logic [atcs_pkg::SAMPLE_W-1:0] sample_reg;
    logic [atcs_pkg::SAMPLE_W-1:0] peak_reg;
    logic [atcs_pkg::SAMPLE_W-1:0] clip_counter_reg;
    logic                          seen_reg;
    logic [atcs_pkg::FRAME_W-1:0]  first_nz_reg;
    logic [atcs_pkg::FRAME_W-1:0]  last_nz_reg;
    logic [atcs_pkg::FRAME_W-1:0]  frame_reg;
    logic [POS_W-1:0]              pos_reg;

    logic [atcs_pkg::CH_W-1:0]     ech;
    logic signed [atcs_pkg::SAMPLE_W-1:0] v;
    logic [atcs_pkg::SAMPLE_W-1:0] mag;
    logic                          clip_hi;
    logic                          clip_lo;
    logic [atcs_pkg::SAMPLE_W-1:0] sample_next;
    logic                          nonzero;
    logic                          frame_end;

    assign tap_adv = tap.valid && (!m_valid_reg || m_ready);

    assign ech       = atcs_pkg::eff_channels(cfg.channel_count, MAX_CHANNELS);
    assign frame_end = (atcs_pkg::CH_W'(pos_reg) + atcs_pkg::CH_W'(1)) >= ech;

    assign v       = tap.sample;
    assign mag     = v[atcs_pkg::SAMPLE_W-1] ? (~tap.sample + 1'b1) : tap.sample;
    assign nonzero = tap.sample != '0;
    assign clip_hi = !cfg.normalise && (v > atcs_pkg::UNITY_Q23);
    assign clip_lo = !cfg.normalise && (v < atcs_pkg::NEG_UNITY_Q23);

    always_comb begin
        sample_next = tap.sample;
        if (clip_hi) begin
            sample_next = atcs_pkg::UNITY_Q23;
        end else if (clip_lo) begin
            sample_next = atcs_pkg::NEG_UNITY_Q23;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            peak_reg         <= '0;
            clip_counter_reg <= '0;
            seen_reg         <= 1'b0;
            first_nz_reg     <= '0;
            last_nz_reg      <= '0;
            frame_reg        <= '0;
            pos_reg          <= '0;
        end else begin
            if (tap_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (tap_adv) begin
                if ((clip_hi || clip_lo) && clip_counter_reg != atcs_pkg::COUNT_MAX) begin
                    clip_counter_reg <= clip_counter_reg + 1'b1;
                end
                if (nonzero) begin
                    if (!seen_reg) begin
                        seen_reg     <= 1'b1;
                        first_nz_reg <= frame_reg;
                    end
                    last_nz_reg <= frame_reg;
                    if (mag > peak_reg) begin
                        peak_reg <= mag;
                    end
                end
                if (frame_end) begin
                    pos_reg <= '0;
                    if (frame_reg != atcs_pkg::FRAME_MAX) begin
                        frame_reg <= frame_reg + 1'b1;
                    end
                end else begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tap_adv) begin
            sample_reg <= sample_next;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_sample_out          = sample_reg;
    assign m_peak_abs            = peak_reg;
    assign m_clip_count          = clip_counter_reg;
    assign m_any_nonzero         = seen_reg;
    assign m_first_nonzero_frame = first_nz_reg;
    assign m_last_nonzero_frame  = last_nz_reg;

    a_peak_rises: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> peak_reg >= $past(peak_reg))
        else $error("peak fell");

    a_unseen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> first_nz_reg == '0 && last_nz_reg == '0)
        else $error("nonzero frame index before any nonzero sample");

    a_first_le_last: assert property (@(posedge aclk) disable iff (!aresetn)
        first_nz_reg <= last_nz_reg)
        else $error("first nonzero frame after last");

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import atcs_pkg::*;

    localparam int MAX_CH        = DEF_MAX_CHANNELS;
    localparam int STORE_DEPTH   = DEF_TRIM_STORE_SAMPLES;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_e;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] clips;
        logic                nonzero;
        logic [FRAME_W-1:0]  first_frame;
        logic [FRAME_W-1:0]  last_frame;
    } stats_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index   = '0;
    logic [CFG_DATA_W-1:0]         cfg_data    = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_W-1:0]    s_sample_in = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0]    m_sample_out;
    logic [SAMPLE_W-1:0]           m_peak_abs;
    logic [SAMPLE_W-1:0]           m_clip_count;
    logic                          m_any_nonzero;
    logic [FRAME_W-1:0]            m_first_nonzero_frame;
    logic [FRAME_W-1:0]            m_last_nonzero_frame;

    // register shadow
    logic [CH_CNT_W-1:0]  cfg_chan_cnt = 4'd1;
    logic [END_W-1:0]     cfg_end      = '0;
    logic                 cfg_norm     = 1'b0;

    // predicted block state
    logic [START_W-1:0]   start_left   = '0;
    int                   in_pos       = 0;
    logic [SAMPLE_W-1:0]  trim_store [STORE_DEPTH];
    int                   wr_ptr       = 0;
    int                   held_count   = 0;
    int                   out_pos      = 0;
    logic [FRAME_W-1:0]   frame_idx    = '0;
    logic [SAMPLE_W-1:0]  peak_mag     = '0;
    logic [SAMPLE_W-1:0]  clip_total   = '0;
    logic                 nz_seen      = 1'b0;
    logic [FRAME_W-1:0]   first_nz     = '0;
    logic [FRAME_W-1:0]   last_nz      = '0;

    stats_t               expected_stats [$];
    logic [SAMPLE_W-1:0]  sample_fifo [$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;

    int                   gap_max   = 0;
    int                   burst_max = 1;
    ready_mode_e          ready_mode = READY_ALWAYS;
    int                   stall_pct  = 0;
    int                   holds_asked  = 0;
    int                   holds_served = 0;
    int                   hold_left    = 0;
    logic [31:0]          stall_mask   = 32'hA5C3_0F71;
    logic [4:0]           mask_pos     = '0;

    audio_trim_clip_stats dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_sample_in           (s_sample_in),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_sample_out          (m_sample_out),
        .m_peak_abs            (m_peak_abs),
        .m_clip_count          (m_clip_count),
        .m_any_nonzero         (m_any_nonzero),
        .m_first_nonzero_frame (m_first_nonzero_frame),
        .m_last_nonzero_frame  (m_last_nonzero_frame)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int active_channels();
        if (cfg_chan_cnt == '0) begin
            return 1;
        end
        if (int'(cfg_chan_cnt) > MAX_CH) begin
            return MAX_CH;
        end
        return int'(cfg_chan_cnt);
    endfunction

    function automatic int trim_delay();
        int d;
        d = int'(cfg_end) * active_channels();
        return (d >= STORE_DEPTH) ? 0 : d;
    endfunction

    function automatic void advance_trim_clip(input logic [SAMPLE_W-1:0] raw);
        int                  ch;
        bit                  frame_end;
        int                  rd;
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] res;
        stats_t              r;
        ch = active_channels();
        frame_end = (in_pos + 1 >= ch);
        in_pos = frame_end ? 0 : in_pos + 1;
        if (start_left != '0) begin
            if (frame_end) begin
                start_left = start_left - 1'b1;
            end
            return;
        end
        if (held_count < trim_delay()) begin
            trim_store[wr_ptr] = raw;
            wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
            held_count++;
            return;
        end
        trim_store[wr_ptr] = raw;
        rd = (wr_ptr + STORE_DEPTH - held_count) % STORE_DEPTH;
        v = trim_store[rd];
        wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
        mag = v[SAMPLE_W-1] ? (~v + 1'b1) : v;
        res = v;
        if (!cfg_norm) begin
            if ($signed(v) > UNITY_Q23) begin
                res = UNITY_Q23;
                if (clip_total != COUNT_MAX) clip_total = clip_total + 1'b1;
            end else if ($signed(v) < NEG_UNITY_Q23) begin
                res = NEG_UNITY_Q23;
                if (clip_total != COUNT_MAX) clip_total = clip_total + 1'b1;
            end
        end
        if (mag != '0) begin
            if (!nz_seen) begin
                nz_seen  = 1'b1;
                first_nz = frame_idx;
            end
            last_nz = frame_idx;
            if (mag > peak_mag) peak_mag = mag;
        end
        if (out_pos + 1 >= ch) begin
            out_pos = 0;
            if (frame_idx != FRAME_MAX) frame_idx = frame_idx + 1'b1;
        end else begin
            out_pos++;
        end
        r.sample      = res;
        r.peak        = peak_mag;
        r.clips       = clip_total;
        r.nonzero     = nz_seen;
        r.first_frame = first_nz;
        r.last_frame  = last_nz;
        expected_stats.push_back(r);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int                  sel;
        logic [SAMPLE_W-1:0] val;
        sel = $urandom_range(99);
        if (sel < 12) begin
            val = '0;
        end else if (sel < 45) begin
            val = $urandom_range(32'd16777216) - 32'd8388608;
        end else if (sel < 60) begin
            val = UNITY_Q23 + $urandom_range(2) - 1;
            if ($urandom_range(1) == 1) val = -val;
        end else if (sel < 68) begin
            case ($urandom_range(3))
                0: val = 32'h7FFF_FFFF;
                1: val = 32'h8000_0000;
                2: val = 32'h8000_0001;
                default: val = 32'hFFFF_FFFF;
            endcase
        end else begin
            val = $urandom;
        end
        return val;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        stats_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_stats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("mismatch: transaction %h with nothing expected", m_sample_out);
                end
            end else begin
                want = expected_stats.pop_front();
                compare_field("sample_out", want.sample, $unsigned(m_sample_out));
                compare_field("peak_abs", want.peak, m_peak_abs);
                compare_field("clip_count", want.clips, m_clip_count);
                compare_field("any_nonzero", want.nonzero, m_any_nonzero);
                compare_field("first_nonzero_frame", want.first_frame, m_first_nonzero_frame);
                compare_field("last_nonzero_frame", want.last_frame, m_last_nonzero_frame);
            end
        end
    end

    always @(negedge aclk) begin
        if (holds_served != holds_asked) begin
            holds_served <= holds_asked;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (ready_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_RANDOM: m_ready <= ($urandom_range(99) >= stall_pct);
                default:      m_ready <= stall_mask[mask_pos];
            endcase
            mask_pos <= mask_pos + 1'b1;
            if (mask_pos == '1) stall_mask <= $urandom | 32'h1;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CHANNEL_COUNT: cfg_chan_cnt = val[CH_CNT_W-1:0];
            CFG_TRIM_START:    start_left   = val[START_W-1:0];
            CFG_TRIM_END:      cfg_end  = val[END_W-1:0];
            CFG_NORMALISE:     cfg_norm = val[0];
            default: ;
        endcase
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_sample_in <= smp;
        do @(posedge aclk); while (!s_ready);
        advance_trim_clip(smp);
    endtask

    task automatic stream_samples();
        int burst;
        int gap;
        burst = $urandom_range(burst_max, 1);
        while (sample_fifo.size() != 0) begin
            send_sample(sample_fifo.pop_front());
            burst--;
            if (sample_fifo.size() == 0) begin
                @(negedge aclk) s_valid <= 1'b0;
            end else if (burst == 0) begin
                gap = $urandom_range(gap_max, 0);
                if (gap != 0) begin
                    @(negedge aclk) s_valid <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
                burst = $urandom_range(burst_max, 1);
            end
        end
    endtask

    task automatic drain_results();
        @(posedge aclk);
        while (expected_stats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_pacing(input bit steady);
        if (steady) begin
            gap_max    = 0;
            burst_max  = 1;
            ready_mode = READY_ALWAYS;
        end else begin
            gap_max    = $urandom_range(8);
            burst_max  = $urandom_range(24, 1);
            ready_mode = ready_mode_e'($urandom_range(2));
            stall_pct  = $urandom_range(70, 10);
        end
    endtask

    task automatic test_first_frame();
        set_pacing(1'b0);
        write_reg(CFG_CHANNEL_COUNT, 2);
        write_reg(CFG_TRIM_START, 0);
        write_reg(CFG_TRIM_END, 0);
        write_reg(CFG_NORMALISE, 0);
        sample_fifo = '{32'h0, 32'h5, 32'h0, 32'hFFFF_FFFD};
        stream_samples();
        drain_results();
    endtask

    task automatic test_clip_bounds();
        write_reg(CFG_CHANNEL_COUNT, 1);
        sample_fifo = '{UNITY_Q23, UNITY_Q23 + 1, NEG_UNITY_Q23, NEG_UNITY_Q23 - 1,
                        32'h7FFF_FFFF, 32'h8000_0000};
        stream_samples();
        drain_results();
        write_reg(CFG_NORMALISE, 1);
        sample_fifo = '{32'h8000_0001, UNITY_Q23 + 1};
        stream_samples();
        drain_results();
        write_reg(CFG_NORMALISE, 0);
    endtask

    task automatic test_channel_limits();
        write_reg(CFG_CHANNEL_COUNT, 0);
        sample_fifo = '{32'h0000_0100};
        stream_samples();
        drain_results();
        write_reg(CFG_CHANNEL_COUNT, 15);
        sample_fifo = '{32'h0, 32'hFFFF_0000, 32'h0};
        stream_samples();
        drain_results();
        // shrink the frame while mid-frame
        write_reg(CFG_CHANNEL_COUNT, 3);
        sample_fifo = '{32'h0000_0007, 32'h0};
        stream_samples();
        drain_results();
        write_reg(CFG_CHANNEL_COUNT, 9);
    endtask

    task automatic test_start_trim();
        write_reg(CFG_CHANNEL_COUNT, 2);
        write_reg(CFG_TRIM_START, 24'hFF_FFFF);
        sample_fifo = '{32'h1234_5678, 32'h0};
        stream_samples();
        drain_results();
        write_reg(CFG_TRIM_START, 1);
        sample_fifo = '{32'h0, 32'h0000_0042, 32'hFFFF_FF00};
        stream_samples();
        drain_results();
    endtask

    task automatic test_end_trim_limits();
        write_reg(CFG_TRIM_END, 8192);
        sample_fifo = '{32'h0000_0011};
        stream_samples();
        drain_results();
        write_reg(CFG_TRIM_END, 16383);
        sample_fifo = '{32'hFF80_0000};
        stream_samples();
        drain_results();
        write_reg(CFG_TRIM_END, 2);
        repeat (6) sample_fifo.push_back(pick_sample());
        stream_samples();
        drain_results();
        // shortened delay keeps what is already held
        write_reg(CFG_TRIM_END, 0);
        repeat (2) sample_fifo.push_back(pick_sample());
        stream_samples();
        drain_results();
    endtask

    task automatic test_backpressure();
        set_pacing(1'b1);
        @(posedge aclk);
        holds_asked++;
        repeat (150) sample_fifo.push_back(pick_sample());
        stream_samples();
        drain_results();
    endtask

    task automatic shuffle_settings();
        int eff;
        if ($urandom_range(9) < 7) write_reg(CFG_CHANNEL_COUNT, $urandom_range(15));
        if ($urandom_range(1) == 1) write_reg(CFG_TRIM_START, $urandom_range(3));
        eff = active_channels();
        if ($urandom_range(9) < 6) begin
            if (eff > 1 && $urandom_range(6) == 0) begin
                write_reg(CFG_TRIM_END, $urandom_range(16383, 16383 / eff + 1));
            end else begin
                write_reg(CFG_TRIM_END, $urandom_range(96 / eff));
            end
        end
        if ($urandom_range(1) == 1) write_reg(CFG_NORMALISE, $urandom_range(1));
    endtask

    task automatic test_random_streams(input int phases);
        int n;
        for (int p = 0; p < phases; p++) begin
            shuffle_settings();
            set_pacing(p == 0);
            n = $urandom_range(160, 110);
            repeat (n) sample_fifo.push_back(pick_sample());
            stream_samples();
            drain_results();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_first_frame();
        test_clip_bounds();
        test_channel_limits();
        test_start_trim();
        test_end_trim_limits();
        test_backpressure();
        test_random_streams(9);
        drain_results();
        if (mismatch_count == 0 && expected_stats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
